FILE: sv/svb_pkg.sv
// ----------------------------------------------------------------------------
// svb_pkg: shared types and constants for the stereo vu ballistics block
// widths, register codes, reset values, db scaling and the log2 fraction
// table generator used by the db lanes
// ----------------------------------------------------------------------------
package svb_pkg;

	// field and state widths
	localparam int AMP_W   = 16;                 // input amplitude, q12.4
	localparam int COEF_W  = 16;                 // q0.16 coefficients
	localparam int VAL_W   = 28;                 // tracked values, q12.16
	localparam int FRAC_W  = 16;                 // log2 fraction bits
	localparam int EXP_W   = 5;                  // signed integer part of log2
	localparam int LOG_W   = EXP_W + FRAC_W;     // signed log2, q5.16
	localparam int SCALE_W = 24;                 // signed db scale constant
	localparam int PROD_W  = LOG_W + SCALE_W;    // log2 times scale
	localparam int DB_W    = 11;                 // result in 1/16 db
	localparam int NUM_LANES = 4;
	localparam int IN_W    = NUM_LANES * AMP_W;
	localparam int OUT_W   = ((NUM_LANES * DB_W + 7) / 8) * 8;
	localparam int CFG_IDX_W = 2;

	// 16 * 20 * log10(2) in q.16
	localparam logic signed [SCALE_W-1:0] DB_SCALE = 24'sd6313057;
	localparam logic signed [DB_W-1:0] DB_MIN = -11'sd960;
	localparam logic signed [DB_W-1:0] DB_MAX = 11'sd48;

	// log2 exponent of the full-scale reference (2048 in q12.16 -> bit 27)
	localparam logic [EXP_W-1:0] REF_EXP = 5'd27;
	// amplitude floor 1.0 in q12.16
	localparam logic [VAL_W-1:0] ONE_Q16 = 28'h001_0000;
	localparam int FLOOR_BIT = 16;

	// default table resolution
	localparam int LOG_TABLE_BITS_DEF = 6;

	// configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_RELEASE = 2'd1,
		REG_DECAY   = 2'd2
	} cfg_reg_t;

	localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd19661;
	localparam logic [COEF_W-1:0] RELEASE_RST = 16'd3277;
	localparam logic [COEF_W-1:0] DECAY_RST   = 16'd39322;

	// stage enables handed to every db lane
	typedef struct packed {
		logic s2;
		logic s3;
	} lane_en_t;

	// floor(log2(1 + i / 2^bits) * 65536), by repeated squaring in q2.30
	function automatic logic [FRAC_W-1:0] log_frac_calc(input int unsigned bits,
			input int unsigned i);
		logic [63:0] x;
		logic [FRAC_W-1:0] r;
		x = 64'((64'd1 << bits) + 64'(i)) << (30 - bits);
		r = '0;
		for (int b = 0; b < FRAC_W; b++) begin
			x = (x * x) >> 30;
			r = {r[FRAC_W-2:0], 1'b0};
			if (x >= (64'd2 << 30)) begin
				r[0] = 1'b1;
				x = x >> 1;
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/svb_ballistics.sv
// ----------------------------------------------------------------------------
// svb_ballistics: attack/release level and peak hold for one channel
// state moves on every accepted frame and doubles as the first pipe stage
// ----------------------------------------------------------------------------
module svb_ballistics (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [svb_pkg::AMP_W-1:0]     level_in,
	input  logic [svb_pkg::AMP_W-1:0]     peak_in,
	input  logic [svb_pkg::COEF_W-1:0]    attack_coeff,
	input  logic [svb_pkg::COEF_W-1:0]    release_coeff,
	input  logic [svb_pkg::COEF_W-1:0]    peak_decay,
	output logic [svb_pkg::VAL_W-1:0]     level_q,
	output logic [svb_pkg::VAL_W-1:0]     peak_q
);

	localparam int PW = svb_pkg::COEF_W + svb_pkg::VAL_W;

	logic [svb_pkg::VAL_W-1:0] x, p, diff, step, level_next, peak_next;
	logic [svb_pkg::COEF_W-1:0] coef;
	logic [PW-1:0] lvl_prod, pk_prod;
	logic rising;

	// smoothed level: move toward the new rms by attack or release
	always_comb begin
		x = {level_in, {(svb_pkg::VAL_W - svb_pkg::AMP_W){1'b0}}};
		rising = x > level_q;
		diff = rising ? (x - level_q) : (level_q - x);
		coef = rising ? attack_coeff : release_coeff;
		lvl_prod = PW'(coef) * PW'(diff);
		step = lvl_prod[PW-1:svb_pkg::COEF_W];
		level_next = rising ? (level_q + step) : (level_q - step);
	end

	// peak: jump up at once, otherwise decay
	always_comb begin
		p = {peak_in, {(svb_pkg::VAL_W - svb_pkg::AMP_W){1'b0}}};
		pk_prod = PW'(peak_q) * PW'(peak_decay);
		peak_next = (p > peak_q) ? p : pk_prod[PW-1:svb_pkg::COEF_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			peak_q  <= '0;
		end else if (load) begin
			level_q <= level_next;
			peak_q  <= peak_next;
		end
	end

endmodule

FILE: sv/svb_db_lane.sv
// ----------------------------------------------------------------------------
// svb_db_lane: amplitude to 1/16 db for one value
// s2 leading-one log2 with fraction table, s3 scale multiply,
// rounding and clamp after s3
// ----------------------------------------------------------------------------
module svb_db_lane #(
	parameter int LOG_TABLE_BITS = svb_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                               clk,
	input  svb_pkg::lane_en_t                  en,
	input  logic [svb_pkg::VAL_W-1:0]          value,
	output logic signed [svb_pkg::DB_W-1:0]    db
);

	localparam int TAB_N = 1 << LOG_TABLE_BITS;
	localparam int RND_W = svb_pkg::PROD_W + 1;
	localparam int Q_W   = RND_W - 32;

	logic [svb_pkg::FRAC_W-1:0] frac_tab [TAB_N];

	// fraction table, fixed at elaboration
	for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
		assign frac_tab[gi] = svb_pkg::log_frac_calc(LOG_TABLE_BITS, gi);
	end

	logic [svb_pkg::VAL_W-1:0] vf, shifted;
	logic [svb_pkg::EXP_W-1:0] e, sh, ed;
	logic [LOG_TABLE_BITS-1:0] idx;
	logic signed [svb_pkg::LOG_W-1:0] log_s2;
	logic signed [svb_pkg::PROD_W-1:0] prod_s3;
	logic signed [RND_W-1:0] rnd;
	logic signed [Q_W-1:0] q;

	// floor at 1.0, leading one, table index
	always_comb begin
		vf = (value < svb_pkg::ONE_Q16) ? svb_pkg::ONE_Q16 : value;
		e = svb_pkg::EXP_W'(svb_pkg::FLOOR_BIT);
		for (int i = svb_pkg::FLOOR_BIT; i < svb_pkg::VAL_W; i++) begin
			if (vf[i]) e = svb_pkg::EXP_W'(i);
		end
		sh = e - svb_pkg::EXP_W'(LOG_TABLE_BITS);
		shifted = vf >> sh;
		idx = shifted[LOG_TABLE_BITS-1:0];
		ed = e - svb_pkg::REF_EXP;
	end

	// log2 relative to full scale, then scale to 1/16 db
	always_ff @(posedge clk) begin
		if (en.s2) log_s2 <= {ed, frac_tab[idx]};
		if (en.s3) prod_s3 <= log_s2 * svb_pkg::DB_SCALE;
	end

	// round half up, clamp
	always_comb begin
		rnd = RND_W'(prod_s3) + (RND_W'(1) <<< 31);
		q = rnd[RND_W-1:32];
		if (q < Q_W'(svb_pkg::DB_MIN))
			db = svb_pkg::DB_MIN;
		else if (q > Q_W'(svb_pkg::DB_MAX))
			db = svb_pkg::DB_MAX;
		else
			db = q[svb_pkg::DB_W-1:0];
	end

endmodule

FILE: sv/stereo_vu_ballistics_db.sv
// ----------------------------------------------------------------------------
// stereo_vu_ballistics_db: stereo vu meter ballistics with db readout
// two channel trackers feed four db lanes; results merge into one transfer
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one transfer per audio frame carrying rms and peak amplitudes
//   of both channels (unsigned q12.4). m_* stream: one transfer per frame
//   with smoothed level and held peak of both channels in 1/16 db, -60..+3.
//   cfg_*: register writes (attack, release, peak decay); cfg_ready is
//   always high. write only while no frame is in flight.
// pipeline and throughput
//   an accepted frame passes the tracker state, log2 stage, scale multiply
//   and output register, in that order, before it shows on m_tvalid. one frame
//   per cycle is sustained while m_tready stays high: the tracker update is a
//   combinational multiply and add, and the lanes are fully pipelined.
// reset
//   arst_n clears the tracked levels and peaks to silence, loads the
//   default coefficients and empties the pipeline.
// stall
//   each stage holds while the next one is full and stalled; the input keeps
//   taking frames until the pipe in front of it is full.
// ----------------------------------------------------------------------------
module stereo_vu_ballistics_db #(
	parameter int LOG_TABLE_BITS = svb_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// level_left, peak_left, level_right, peak_right (lowest bit up)
	input  logic [svb_pkg::IN_W-1:0]          s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// level_db_left, peak_db_left, level_db_right, peak_db_right, zero pad
	output logic [svb_pkg::OUT_W-1:0]         m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [svb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [svb_pkg::COEF_W-1:0]        cfg_data
);

	localparam int DBS_W = svb_pkg::NUM_LANES * svb_pkg::DB_W;

	logic [svb_pkg::COEF_W-1:0] attack_q, release_q, decay_q;
	logic v1_q, v2_q, v3_q, out_v_q;
	logic rdy_out, rdy3, rdy2, rdy1, accept;
	svb_pkg::lane_en_t lane_en;
	logic [svb_pkg::VAL_W-1:0] vals [svb_pkg::NUM_LANES];
	logic signed [svb_pkg::DB_W-1:0] dbs [svb_pkg::NUM_LANES];
	logic [DBS_W-1:0] out_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= svb_pkg::ATTACK_RST;
			release_q <= svb_pkg::RELEASE_RST;
			decay_q   <= svb_pkg::DECAY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				svb_pkg::REG_ATTACK:  attack_q  <= cfg_data;
				svb_pkg::REG_RELEASE: release_q <= cfg_data;
				svb_pkg::REG_DECAY:   decay_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage flow control
	assign rdy_out   = !out_v_q || m_tready;
	assign rdy3      = !v3_q || rdy_out;
	assign rdy2      = !v2_q || rdy3;
	assign rdy1      = !v1_q || rdy2;
	assign s_tready  = rdy1;
	assign accept    = s_tvalid && rdy1;
	assign lane_en.s2 = rdy2;
	assign lane_en.s3 = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy1)    v1_q    <= accept;
			if (rdy2)    v2_q    <= v1_q;
			if (rdy3)    v3_q    <= v2_q;
			if (rdy_out) out_v_q <= v3_q;
		end
	end

	// channel trackers
	svb_ballistics u_trk_left (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.level_in      (s_tdata[0*svb_pkg::AMP_W +: svb_pkg::AMP_W]),
		.peak_in       (s_tdata[1*svb_pkg::AMP_W +: svb_pkg::AMP_W]),
		.attack_coeff  (attack_q),
		.release_coeff (release_q),
		.peak_decay    (decay_q),
		.level_q       (vals[0]),
		.peak_q        (vals[1])
	);

	svb_ballistics u_trk_right (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.level_in      (s_tdata[2*svb_pkg::AMP_W +: svb_pkg::AMP_W]),
		.peak_in       (s_tdata[3*svb_pkg::AMP_W +: svb_pkg::AMP_W]),
		.attack_coeff  (attack_q),
		.release_coeff (release_q),
		.peak_decay    (decay_q),
		.level_q       (vals[2]),
		.peak_q        (vals[3])
	);

	// db lanes
	for (genvar gl = 0; gl < svb_pkg::NUM_LANES; gl++) begin : g_lane
		svb_db_lane #(
			.LOG_TABLE_BITS (LOG_TABLE_BITS)
		) u_lane (
			.clk   (clk),
			.en    (lane_en),
			.value (vals[gl]),
			.db    (dbs[gl])
		);
	end

	// merge lanes into the output register
	always_ff @(posedge clk) begin
		if (rdy_out) out_q <= {dbs[3], dbs[2], dbs[1], dbs[0]};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(svb_pkg::OUT_W - DBS_W){1'b0}}, out_q};

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q)
		else $error("accepted frame did not enter the first stage");

	a_s3_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && !rdy_out) |=> v3_q)
		else $error("multiply stage dropped a frame while stalled");

	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> s_tready)
		else $error("input not ready with an empty first stage");

	a_db_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ($signed(out_q[svb_pkg::DB_W-1:0]) >= svb_pkg::DB_MIN &&
			$signed(out_q[svb_pkg::DB_W-1:0]) <= svb_pkg::DB_MAX &&
			$signed(out_q[3*svb_pkg::DB_W +: svb_pkg::DB_W]) >= svb_pkg::DB_MIN &&
			$signed(out_q[3*svb_pkg::DB_W +: svb_pkg::DB_W]) <= svb_pkg::DB_MAX))
		else $error("db result outside the clamp range");

endmodule
